[rtl/core/symmetric_line_rasterizer_unit_assert.svh]
// assertion macros used by the line rasterizer controller
// no dependencies; included by files that carry concurrent assertions
`ifndef SYMMETRIC_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define SYMMETRIC_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/slr_pkg.sv]
// types, constants and helpers for the symmetric line rasterizer
// no dependencies; imported by every rasterizer module and interface
package slr_pkg;

	localparam int COORD_W   = 7;
	localparam int COLOUR_W  = 8;
	localparam int CLIP_W    = 8;
	localparam int DEC_W     = 10;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 2;

	typedef logic [COORD_W-1:0]         coord_t;
	typedef logic [COLOUR_W-1:0]        colour_t;
	typedef logic [CLIP_W-1:0]          clip_t;
	typedef logic signed [DEC_W-1:0]    dec_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	// drawable screen area
	localparam clip_t SCREEN_WIDTH  = 8'd128;
	localparam clip_t SCREEN_HEIGHT = 8'd128;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 2'd3;

	// reset values of the clip window
	localparam clip_t CLIP_LEFT_RST   = 8'd0;
	localparam clip_t CLIP_RIGHT_RST  = 8'd128;
	localparam clip_t CLIP_TOP_RST    = 8'd0;
	localparam clip_t CLIP_BOTTOM_RST = 8'd128;

	// one line command word
	typedef struct packed {
		coord_t  x_start;
		coord_t  y_start;
		coord_t  x_end;
		coord_t  y_end;
		colour_t red;
		colour_t green;
		colour_t blue;
	} line_cmd_t;

	// one point-pair result word
	typedef struct packed {
		coord_t  front_x;
		coord_t  front_y;
		logic    front_valid;
		coord_t  back_x;
		coord_t  back_y;
		logic    back_valid;
		colour_t pixel_red;
		colour_t pixel_green;
		colour_t pixel_blue;
		logic    last;
	} pair_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic setup;
		logic emit;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic slot_free;
		logic last;
	} status_t;

	// point lies on screen and inside the clip window
	function automatic logic in_window(coord_t x, coord_t y, clip_t left, clip_t right,
			clip_t top, clip_t bottom);
		clip_t xe;
		clip_t ye;
		xe = {1'b0, x};
		ye = {1'b0, y};
		return (xe < SCREEN_WIDTH) && (ye < SCREEN_HEIGHT) &&
			(xe >= left) && (xe < right) && (ye >= top) && (ye < bottom);
	endfunction

endpackage

[rtl/core/slr_if.sv]
// valid/ready channel interfaces for line commands and point-pair results
// depends on slr_pkg for the field types
interface slr_cmd_if import slr_pkg::*; ();
	logic    valid;
	logic    ready;
	coord_t  x_start;
	coord_t  y_start;
	coord_t  x_end;
	coord_t  y_end;
	colour_t red;
	colour_t green;
	colour_t blue;

	modport source (output valid, x_start, y_start, x_end, y_end, red, green, blue,
		input ready);
	modport sink (input valid, x_start, y_start, x_end, y_end, red, green, blue,
		output ready);
endinterface

interface slr_pts_if import slr_pkg::*; ();
	logic    valid;
	logic    ready;
	coord_t  front_x;
	coord_t  front_y;
	logic    front_valid;
	coord_t  back_x;
	coord_t  back_y;
	logic    back_valid;
	colour_t pixel_red;
	colour_t pixel_green;
	colour_t pixel_blue;
	logic    last;

	modport source (output valid, front_x, front_y, front_valid, back_x, back_y,
		back_valid, pixel_red, pixel_green, pixel_blue, last, input ready);
	modport sink (input valid, front_x, front_y, front_valid, back_x, back_y,
		back_valid, pixel_red, pixel_green, pixel_blue, last, output ready);
endinterface

[rtl/core/slr_datapath.sv]
// clip registers, line setup, double-ended stepping and the result register
// depends on slr_pkg
module slr_datapath import slr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  clip_t                cfg_wdata,
	input  line_cmd_t            cmd_word,
	input  ctl_t                 ctl,
	output status_t              status,
	output pair_word_t           res_word,
	output logic                 res_valid,
	input  logic                 res_ready
);

	clip_t clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
	line_cmd_t cmd_q;

	// stepping state
	coord_t fx_q, fy_q, bx_q, by_q;
	dec_t   p_q, inc_a_q, inc_b_q;
	cnt_t   rem_q;
	logic   lone_q, axis_q, major_x_q, maj_pos_q, min_pos_q;

	// result register
	pair_word_t res_q;
	logic       res_valid_q;

	// setup terms
	logic   x_fwd, y_fwd, vert, horiz, axis, maj_x;
	coord_t adx, ady, dmaj, dmin, dm1, span, lo;
	logic [7:0] span2;
	cnt_t   nres_axis, nres_gen;
	dec_t   dmin2, dmaj2;

	// step terms
	logic   take_minor, back_en, last_word;
	coord_t f_maj_d, b_maj_d, f_min_d, b_min_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= CLIP_LEFT_RST;
			clip_right_q  <= CLIP_RIGHT_RST;
			clip_top_q    <= CLIP_TOP_RST;
			clip_bottom_q <= CLIP_BOTTOM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLIP_LEFT:   clip_left_q   <= cfg_wdata;
				CFG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata;
				CFG_CLIP_TOP:    clip_top_q    <= cfg_wdata;
				CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// line geometry from the captured command
	always_comb begin
		x_fwd = cmd_q.x_end >= cmd_q.x_start;
		y_fwd = cmd_q.y_end >= cmd_q.y_start;
		adx   = x_fwd ? cmd_q.x_end - cmd_q.x_start : cmd_q.x_start - cmd_q.x_end;
		ady   = y_fwd ? cmd_q.y_end - cmd_q.y_start : cmd_q.y_start - cmd_q.y_end;
		vert  = (adx == '0);
		horiz = !vert && (ady == '0);
		axis  = vert || horiz;
		maj_x = axis ? horiz : (adx >= ady);
		dmaj  = maj_x ? adx : ady;
		dmin  = maj_x ? ady : adx;
		// axis-aligned: two points per word from the low end
		span      = vert ? ady : adx;
		lo        = vert ? (y_fwd ? cmd_q.y_start : cmd_q.y_end)
			: (x_fwd ? cmd_q.x_start : cmd_q.x_end);
		span2     = {1'b0, span} + 8'd2;
		nres_axis = span2[7:1];
		// general: endpoints, inner pairs, then a lone middle when even
		dm1      = dmaj - 7'd1;
		nres_gen = 7'd1 + {1'b0, dm1[6:1]} + {6'd0, ~dmaj[0]};
		dmin2    = {2'b00, dmin, 1'b0};
		dmaj2    = {2'b00, dmaj, 1'b0};
	end

	// command capture and stepping registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_word;
		end
		if (ctl.setup) begin
			axis_q    <= axis;
			major_x_q <= maj_x;
			maj_pos_q <= maj_x ? x_fwd : y_fwd;
			min_pos_q <= maj_x ? y_fwd : x_fwd;
			inc_a_q   <= dmin2;
			inc_b_q   <= dmin2 - dmaj2;
			p_q       <= dmin2 - {3'b000, dmaj};
			if (axis) begin
				lone_q <= ~span[0];
				fx_q   <= vert ? cmd_q.x_start : lo;
				fy_q   <= vert ? lo : cmd_q.y_start;
				bx_q   <= vert ? cmd_q.x_start : lo + 7'd1;
				by_q   <= vert ? lo + 7'd1 : cmd_q.y_start;
			end else begin
				lone_q <= ~dmaj[0];
				fx_q   <= cmd_q.x_start;
				fy_q   <= cmd_q.y_start;
				bx_q   <= cmd_q.x_end;
				by_q   <= cmd_q.y_end;
			end
		end else if (ctl.emit) begin
			fx_q <= fx_q + (major_x_q ? f_maj_d : f_min_d);
			fy_q <= fy_q + (major_x_q ? f_min_d : f_maj_d);
			bx_q <= bx_q + (major_x_q ? b_maj_d : b_min_d);
			by_q <= by_q + (major_x_q ? b_min_d : b_maj_d);
			p_q  <= p_q + (take_minor ? inc_b_q : inc_a_q);
		end
		if (ctl.emit) begin
			res_q <= '{
				front_x:     fx_q,
				front_y:     fy_q,
				front_valid: in_window(fx_q, fy_q, clip_left_q, clip_right_q,
					clip_top_q, clip_bottom_q),
				back_x:      back_en ? bx_q : '0,
				back_y:      back_en ? by_q : '0,
				back_valid:  back_en && in_window(bx_q, by_q, clip_left_q, clip_right_q,
					clip_top_q, clip_bottom_q),
				pixel_red:   cmd_q.red,
				pixel_green: cmd_q.green,
				pixel_blue:  cmd_q.blue,
				last:        last_word
			};
		end
	end

	// per-step deltas, modulo the coordinate width
	always_comb begin
		take_minor = !axis_q && !p_q[DEC_W-1];
		f_maj_d    = axis_q ? 7'd2 : (maj_pos_q ? 7'd1 : 7'h7F);
		b_maj_d    = axis_q ? 7'd2 : (maj_pos_q ? 7'h7F : 7'd1);
		f_min_d    = take_minor ? (min_pos_q ? 7'd1 : 7'h7F) : 7'd0;
		b_min_d    = take_minor ? (min_pos_q ? 7'h7F : 7'd1) : 7'd0;
		last_word  = (rem_q == 7'd1);
		back_en    = !(last_word && lone_q);
	end

	// word count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.setup) begin
				rem_q <= axis ? nres_axis : nres_gen;
			end else if (ctl.emit) begin
				rem_q <= rem_q - 7'd1;
			end
			if (ctl.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign status.slot_free = !res_valid_q || res_ready;
	assign status.last      = last_word;
	assign res_word         = res_q;
	assign res_valid        = res_valid_q;

endmodule

[rtl/core/slr_ctrl.sv]
// sequencer for one line: capture, setup, then one word per cycle while the result slot is free
// depends on slr_pkg and the assertion macro header
`include "symmetric_line_rasterizer_unit_assert.svh"

module slr_ctrl import slr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  status_t status,
	output ctl_t    ctl
);

	typedef enum logic [1:0] {
		IDLE,
		SETUP,
		RUN
	} state_t;

	state_t state_q;

	// commands to the datapath
	assign cmd_ready = (state_q == IDLE);
	assign ctl.load  = cmd_valid && cmd_ready;
	assign ctl.setup = (state_q == SETUP);
	assign ctl.emit  = (state_q == RUN) && status.slot_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE:    if (cmd_valid) state_q <= SETUP;
				SETUP:   state_q <= RUN;
				RUN:     if (ctl.emit && status.last) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	`SLR_ASSERT_NEXT(a_last_word_ends_line, clk, arst_n, ctl.emit && status.last,
		state_q == IDLE, "line did not end after its last word")
	`SLR_ASSERT_NEXT(a_blocked_run_holds, clk, arst_n, state_q == RUN && !status.slot_free,
		state_q == RUN, "left run state while the result slot was full")
	`SLR_ASSERT_NOW(a_run_has_words, clk, arst_n, state_q == RUN,
		!$past(ctl.setup) || !$past(ctl.emit), "setup and emit issued together")

endmodule

[rtl/core/symmetric_line_rasterizer_unit.sv]
// Symmetric line rasterizer: takes one line command (two endpoints and a colour) and returns
// the line's points as point-pair words, stepped from both ends at once (an axis-aligned line
// from its low end, two points per word); a line's final word has last set. The command is
// captured, the step terms worked out, then one word a cycle comes from the single stepping
// datapath while the output side keeps up; a line has at most 64 words (a 127-step line). A
// stalled output holds the stepper. The next command is taken once the last word of a line
// sits in the output register. The user must write the clip registers through the cfg port
// only while idle, which the block does not enforce; depends on slr_pkg, slr_if, slr_ctrl and slr_datapath
module symmetric_line_rasterizer_unit import slr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  clip_t                cfg_wdata,
	slr_cmd_if.sink              cmd,
	slr_pts_if.source            pts
);

	line_cmd_t  cmd_word;
	pair_word_t res_word;
	ctl_t       ctl;
	status_t    status;

	// pack the command channel
	assign cmd_word = '{
		x_start: cmd.x_start,
		y_start: cmd.y_start,
		x_end:   cmd.x_end,
		y_end:   cmd.y_end,
		red:     cmd.red,
		green:   cmd.green,
		blue:    cmd.blue
	};

	slr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.status    (status),
		.ctl       (ctl)
	);

	slr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_word  (cmd_word),
		.ctl       (ctl),
		.status    (status),
		.res_word  (res_word),
		.res_valid (pts.valid),
		.res_ready (pts.ready)
	);

	// unpack the result word
	assign pts.front_x     = res_word.front_x;
	assign pts.front_y     = res_word.front_y;
	assign pts.front_valid = res_word.front_valid;
	assign pts.back_x      = res_word.back_x;
	assign pts.back_y      = res_word.back_y;
	assign pts.back_valid  = res_word.back_valid;
	assign pts.pixel_red   = res_word.pixel_red;
	assign pts.pixel_green = res_word.pixel_green;
	assign pts.pixel_blue  = res_word.pixel_blue;
	assign pts.last        = res_word.last;

endmodule
